// ----- src/rle_byte_stream_decoder_top_macros.svh -----
// Assertion macros for the run-length decoder checker.
`ifndef RLE_BYTE_STREAM_DECODER_TOP_MACROS_SVH
`define RLE_BYTE_STREAM_DECODER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RLEBSD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rlebsd: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define RLEBSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rlebsd: next-cycle check failed");

`endif

// ----- src/rlebsd_pkg.sv -----
package rlebsd_pkg;

    localparam logic [1:0] MODE_HEADER  = 2'd0;
    localparam logic [1:0] MODE_LITERAL = 2'd1;
    localparam logic [1:0] MODE_REPEAT  = 2'd2;

    localparam logic [7:0] LITERAL_FLAG = 8'h80;
    localparam logic [7:0] COUNT_MASK   = 8'h7f;

    localparam logic [1:0] CNT_ONE = 2'd1;
    localparam logic [1:0] CNT_TWO = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic step;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic run_start;
        logic run_final;
        logic out_valid;
    } status_t;

endpackage

// ----- src/rlebsd_ctrl.sv -----
module rlebsd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               out_stall,
    input  rlebsd_pkg::status_t status,
    output rlebsd_pkg::cmd_t    cmd
);
    import rlebsd_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_free;

    assign out_free = !status.out_valid || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd.accept = 1'b0;
        cmd.step   = 1'b0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall   = !out_free;
                cmd.accept = in_valid && out_free;
                if (cmd.accept && status.run_start)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.step = out_free;
                if (out_free && status.run_final)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- src/rlebsd_datapath.sv -----
module rlebsd_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          data_byte,
    input  logic                stream_end,
    input  logic                out_stall,
    input  rlebsd_pkg::cmd_t    cmd,
    output rlebsd_pkg::status_t status,
    output logic                out_valid,
    output logic [7:0]          first_byte,
    output logic [7:0]          second_byte,
    output logic [1:0]          byte_count,
    output logic                run_last
);
    import rlebsd_pkg::*;

    logic [1:0] mode_reg;
    logic [1:0] mode_next;
    logic [6:0] rem_reg;
    logic [6:0] rem_next;
    logic [7:0] rep_byte_reg;
    logic [7:0] rep_byte_next;
    logic [6:0] left_reg;
    logic [6:0] left_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] first_reg;
    logic [7:0] first_next;
    logic [7:0] second_reg;
    logic [7:0] second_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       last_reg;
    logic       last_next;
    logic       take_two;
    logic       load;

    assign take_two = (left_reg >= 7'd2);

    always_comb
    begin
        mode_next      = mode_reg;
        rem_next       = rem_reg;
        rep_byte_next  = rep_byte_reg;
        left_next      = left_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        load           = 1'b0;

        if (cmd.accept)
        begin
            case (mode_reg)
                MODE_LITERAL:
                begin
                    load        = 1'b1;
                    first_next  = data_byte;
                    second_next = 8'd0;
                    count_next  = CNT_ONE;
                    last_next   = 1'b1;
                    if (rem_reg > 7'd1)
                    begin
                        rem_next = rem_reg - 7'd1;
                    end
                    else
                    begin
                        rem_next  = 7'd0;
                        mode_next = MODE_HEADER;
                    end
                end
                MODE_REPEAT:
                begin
                    rep_byte_next = data_byte;
                    left_next     = rem_reg;
                    rem_next      = 7'd0;
                    mode_next     = MODE_HEADER;
                end
                default:
                begin
                    rem_next = data_byte[6:0] & COUNT_MASK[6:0];
                    if ((data_byte & LITERAL_FLAG) != 8'd0)
                    begin
                        mode_next = (rem_next != 7'd0) ? MODE_LITERAL : MODE_HEADER;
                    end
                    else
                    begin
                        mode_next = MODE_REPEAT;
                    end
                end
            endcase
            if (stream_end)
            begin
                mode_next = MODE_HEADER;
                rem_next  = 7'd0;
            end
        end

        if (cmd.step)
        begin
            load        = 1'b1;
            first_next  = rep_byte_reg;
            second_next = take_two ? rep_byte_reg : 8'd0;
            count_next  = take_two ? CNT_TWO : CNT_ONE;
            last_next   = (left_reg <= 7'd2);
            left_next   = take_two ? (left_reg - 7'd2) : (left_reg - 7'd1);
        end

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_HEADER;
            rem_reg       <= 7'd0;
            left_reg      <= 7'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            rem_reg       <= rem_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rep_byte_reg <= rep_byte_next;
        first_reg    <= first_next;
        second_reg   <= second_next;
        count_reg    <= count_next;
        last_reg     <= last_next;
    end

    assign status.run_start = (mode_reg == MODE_REPEAT) && (rem_reg != 7'd0);
    assign status.run_final = (left_reg <= 7'd2);
    assign status.out_valid = out_valid_reg;

    assign out_valid   = out_valid_reg;
    assign first_byte  = first_reg;
    assign second_byte = second_reg;
    assign byte_count  = count_reg;
    assign run_last    = last_reg;

endmodule

// ----- src/rle_byte_stream_decoder_top.sv -----
// Run-length byte decoder. One compressed byte per request on the input side;
// a header (bit 7 = literal flag, low 7 bits = count L) is followed by L literal
// bytes, or by one value byte that expands to L copies. Results carry one or two
// bytes each. Headers and literal bytes never stall the input unless the output
// register is full and stalled. A repeat value of length L holds the input
// stalled while it expands into ceil(L/2) results, at most 64, one result per
// cycle from the expansion counter while the output is not stalled. stream_end
// resets the parser to expect a header after its byte is handled.
module rle_byte_stream_decoder_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       stream_end,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] first_byte,
    output logic [7:0] second_byte,
    output logic [1:0] byte_count,
    output logic       run_last
);
    import rlebsd_pkg::*;

    cmd_t    cmd;
    status_t status;

    rlebsd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    rlebsd_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (data_byte),
        .stream_end  (stream_end),
        .out_stall   (out_stall),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .first_byte  (first_byte),
        .second_byte (second_byte),
        .byte_count  (byte_count),
        .run_last    (run_last)
    );

endmodule

// ----- src/rlebsd_checker.sv -----
`include "rle_byte_stream_decoder_top_macros.svh"

module rlebsd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] data_byte,
    input logic       stream_end,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] first_byte,
    input logic [7:0] second_byte,
    input logic [1:0] byte_count,
    input logic       run_last
);

    `RLEBSD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(first_byte) && $stable(second_byte) && $stable(byte_count) && $stable(run_last))

    `RLEBSD_ASSERT_IMPL(a_count_range, out_valid, byte_count == 2'd1 || byte_count == 2'd2)

    `RLEBSD_ASSERT_IMPL(a_single_pad, out_valid && byte_count == 2'd1, second_byte == 8'd0)

    `RLEBSD_ASSERT_IMPL(a_full_blocks_in, out_valid && out_stall, in_stall)

endmodule

bind rle_byte_stream_decoder_top rlebsd_checker u_rlebsd_checker (.*);

// ----- verif/rle_byte_stream_decoder_top_tb.sv -----
module rle_byte_stream_decoder_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rlebsd_pkg::*;

    typedef struct packed {
        logic [7:0] first_b;
        logic [7:0] second_b;
        logic [1:0] cnt;
        logic       run_end;
    } dec_result_t;

    typedef struct {
        logic [7:0]  b;
        logic        e;
        bit          pin;
        int          n;
        dec_result_t r;
    } dir_row_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] data_byte;
    logic       stream_end;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [1:0] byte_count;
    logic       run_last;

    logic [1:0]  dec_mode = MODE_HEADER;
    logic [6:0]  dec_remain = '0;
    dec_result_t run_out[$];
    dec_result_t expect_q[$];

    bit          pin_now;
    int          pin_cnt;
    dec_result_t pin_res;
    bit          idle_en;
    int          err_count;
    int          rnd_n;
    dir_row_t    dir_rows [25];

    rle_byte_stream_decoder_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .stream_end  (stream_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .first_byte  (first_byte),
        .second_byte (second_byte),
        .byte_count  (byte_count),
        .run_last    (run_last)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        begin
            $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
            err_count++;
        end
    endtask

    // expands one compressed byte into its decoded results
    task automatic decode_byte(input logic [7:0] b, input logic e);
        logic [6:0] left;
        begin
            run_out.delete();
            case (dec_mode)
                MODE_LITERAL:
                begin
                    run_out.push_back('{b, 8'h00, CNT_ONE, 1'b1});
                    if (dec_remain > 7'd1)
                    begin
                        dec_remain = dec_remain - 7'd1;
                    end
                    else
                    begin
                        dec_remain = '0;
                        dec_mode = MODE_HEADER;
                    end
                end
                MODE_REPEAT:
                begin
                    left = dec_remain;
                    while (left != 0)
                    begin
                        if (left >= 7'd2)
                        begin
                            left = left - 7'd2;
                            run_out.push_back('{b, b, CNT_TWO, left == 0});
                        end
                        else
                        begin
                            left = '0;
                            run_out.push_back('{b, 8'h00, CNT_ONE, 1'b1});
                        end
                    end
                    dec_remain = '0;
                    dec_mode = MODE_HEADER;
                end
                default:
                begin
                    dec_remain = 7'(b & COUNT_MASK);
                    if ((b & LITERAL_FLAG) != 0)
                    begin
                        dec_mode = (dec_remain != 0) ? MODE_LITERAL : MODE_HEADER;
                    end
                    else
                    begin
                        dec_mode = MODE_REPEAT;
                    end
                end
            endcase
            if (e)
            begin
                dec_mode = MODE_HEADER;
                dec_remain = '0;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            decode_byte(data_byte, stream_end);
            if (pin_now)
            begin
                if (pin_cnt != 0)
                begin
                    expect_q.push_back(pin_res);
                end
            end
            else
            begin
                foreach (run_out[i])
                begin
                    expect_q.push_back(run_out[i]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        dec_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expect_q.size() == 0)
            begin
                report_mismatch("unexpected result, first_byte", first_byte, 0);
            end
            else
            begin
                want = expect_q.pop_front();
                if (first_byte !== want.first_b)
                    report_mismatch("first_byte", first_byte, want.first_b);
                if (second_byte !== want.second_b)
                    report_mismatch("second_byte", second_byte, want.second_b);
                if (byte_count !== want.cnt)
                    report_mismatch("byte_count", byte_count, want.cnt);
                if (run_last !== want.run_end)
                    report_mismatch("run_last", run_last, want.run_end);
            end
        end
    end

    always @(negedge clk)
    begin
        out_stall <= idle_en && ($urandom_range(0, 99) < 14);
    end

    // called at a falling edge, returns at the falling edge after the request is taken
    task automatic send_byte(input logic [7:0] b, input logic e, input bit pin, input int n,
                             input dec_result_t r);
        begin
            while (idle_en && ($urandom_range(0, 99) < 14))
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid <= 1'b1;
            data_byte <= b;
            stream_end <= e;
            pin_now = pin;
            pin_cnt = n;
            pin_res = r;
            @(posedge clk);
            while (in_stall)
            begin
                @(posedge clk);
            end
            @(negedge clk);
        end
    endtask

    task automatic send_rand(input logic [7:0] b, input logic e);
        begin
            send_byte(b, e, 1'b0, 0, '0);
            rnd_n++;
        end
    endtask

    task automatic drain;
        begin
            in_valid <= 1'b0;
            @(negedge clk);
            while (expect_q.size() != 0)
            begin
                @(negedge clk);
            end
        end
    endtask

    function automatic logic [6:0] pick_len();
        int unsigned p;
        begin
            p = $urandom_range(0, 99);
            if (p < 70)
                return 7'($urandom_range(0, 6));
            else if (p < 95)
                return 7'($urandom_range(7, 40));
            else
                return 7'($urandom_range(100, 127));
        end
    endfunction

    function automatic logic rare_end();
        begin
            return $urandom_range(0, 99) < 3;
        end
    endfunction

    initial
    begin
        int unsigned kind;
        logic [6:0]  len;
        bit          paused;

        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = '0;
        stream_end = 1'b0;
        out_stall = 1'b0;
        idle_en = 1'b1;
        pin_now = 1'b0;
        pin_cnt = 0;
        pin_res = '0;
        err_count = 0;
        rnd_n = 0;
        paused = 1'b0;

        dir_rows = '{
            '{8'h80, 1'b0, 1'b1, 0, '0},
            '{8'h00, 1'b0, 1'b1, 0, '0},
            '{8'h5A, 1'b0, 1'b1, 0, '0},
            '{8'h81, 1'b0, 1'b1, 0, '0},
            '{8'hFF, 1'b0, 1'b1, 1, '{8'hFF, 8'h00, CNT_ONE, 1'b1}},
            '{8'h01, 1'b0, 1'b1, 0, '0},
            '{8'h00, 1'b0, 1'b1, 1, '{8'h00, 8'h00, CNT_ONE, 1'b1}},
            '{8'h7F, 1'b0, 1'b1, 0, '0},
            '{8'hA5, 1'b0, 1'b0, 0, '0},
            '{8'h02, 1'b0, 1'b1, 0, '0},
            '{8'hC3, 1'b0, 1'b1, 1, '{8'hC3, 8'hC3, CNT_TWO, 1'b1}},
            '{8'hFF, 1'b0, 1'b1, 0, '0},
            '{8'h11, 1'b0, 1'b1, 1, '{8'h11, 8'h00, CNT_ONE, 1'b1}},
            '{8'h22, 1'b1, 1'b1, 1, '{8'h22, 8'h00, CNT_ONE, 1'b1}},
            '{8'h05, 1'b1, 1'b1, 0, '0},
            '{8'h33, 1'b0, 1'b1, 0, '0},
            '{8'h44, 1'b0, 1'b0, 0, '0},
            '{8'h83, 1'b0, 1'b1, 0, '0},
            '{8'h01, 1'b0, 1'b1, 1, '{8'h01, 8'h00, CNT_ONE, 1'b1}},
            '{8'h80, 1'b0, 1'b1, 1, '{8'h80, 8'h00, CNT_ONE, 1'b1}},
            '{8'h7F, 1'b0, 1'b1, 1, '{8'h7F, 8'h00, CNT_ONE, 1'b1}},
            '{8'h03, 1'b0, 1'b1, 0, '0},
            '{8'h96, 1'b0, 1'b0, 0, '0},
            '{8'hFE, 1'b1, 1'b1, 0, '0},
            '{8'h04, 1'b0, 1'b0, 0, '0}
        };

        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            send_byte(dir_rows[i].b, dir_rows[i].e, dir_rows[i].pin, dir_rows[i].n,
                      dir_rows[i].r);
        end

        while (rnd_n < 300)
        begin
            idle_en = !(rnd_n >= 120 && rnd_n < 200);
            if (!paused && rnd_n >= 150)
            begin
                drain();
                paused = 1'b1;
            end
            kind = $urandom_range(0, 9);
            len = pick_len();
            if (kind < 4)
            begin
                send_rand({1'b1, len}, rare_end());
                for (int k = 0; k < len; k++)
                begin
                    send_rand(8'($urandom_range(0, 255)), rare_end());
                end
            end
            else if (kind < 8)
            begin
                send_rand({1'b0, len}, rare_end());
                send_rand(8'($urandom_range(0, 255)), rare_end());
            end
            else
            begin
                send_rand(8'($urandom_range(0, 255)), kind == 9);
            end
        end

        idle_en = 1'b1;
        in_valid <= 1'b0;
        while (expect_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (80) @(negedge clk);

        if (err_count == 0)
        begin
            $display("rle_byte_stream_decoder_top_tb: done, clean");
        end
        else
        begin
            $display("rle_byte_stream_decoder_top_tb: done, errors");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("rle_byte_stream_decoder_top_tb: done, errors");
        $finish;
    end

endmodule
